// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the frame packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ICFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ICFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/icfp_pkg.sv
// Types, constants and lane tables of the impedance command frame packer.
`default_nettype none

package icfp_pkg;

    localparam int NUM_LANES   = 5;
    localparam int VAL_W       = 34;   // Q16.16 input plus offset, with headroom
    localparam int DIST_W      = 27;   // clamped value minus range floor
    localparam int QUOT_W      = 23;   // (dist * top) >> 16
    localparam int RECIP_W     = 20;   // reciprocal of the span divisor
    localparam int RECIP_SHIFT = 24;
    localparam int CODE_W      = 16;
    localparam int DIV_W       = 11;
    localparam int TOP_W       = 16;

    localparam logic [2:0] LANE_KP  = 3'd0;
    localparam logic [2:0] LANE_KD  = 3'd1;
    localparam logic [2:0] LANE_POS = 3'd2;
    localparam logic [2:0] LANE_SPD = 3'd3;
    localparam logic [2:0] LANE_TOR = 3'd4;

    localparam logic [1:0] CFG_MOTOR_CLASS = 2'd0;
    localparam logic [1:0] CFG_ZERO_OFFSET = 2'd1;
    localparam logic [1:0] CFG_FRAME_ID    = 2'd2;

    typedef enum logic [1:0] {
        MOTOR_30  = 2'd0,
        MOTOR_90  = 2'd1,
        MOTOR_150 = 2'd2,
        MOTOR_320 = 2'd3
    } motor_class_t;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [DIST_W-1:0]       dist_t;
    typedef logic [QUOT_W-1:0]       quot_t;
    typedef logic [CODE_W-1:0]       code_t;
    typedef logic [7:0]              byte_t;
    typedef byte_t [7:0]             frame_t;

    typedef struct packed {
        motor_class_t             cls;
        dist_t [NUM_LANES-1:0]    d;
    } dist_stage_t;

    typedef struct packed {
        motor_class_t             cls;
        quot_t [NUM_LANES-1:0]    q;
    } quot_stage_t;

    typedef struct packed {
        motor_class_t             cls;
        quot_t [NUM_LANES-1:0]    q;
        code_t [NUM_LANES-1:0]    est;
    } est_stage_t;

    // Upper clamp limit of a lane, Q16.16.
    function automatic val_t lane_hi(input logic [2:0] lane, input motor_class_t cls);
        unique case (lane)
            LANE_KP:  lane_hi = 34'sd98304000;
            LANE_KD:  lane_hi = 34'sd3276800;
            LANE_POS: lane_hi = 34'sd819200;
            LANE_SPD: lane_hi = 34'sd1179648;
            LANE_TOR:
            begin
                unique case (cls)
                    MOTOR_30:  lane_hi = 34'sd1966080;
                    MOTOR_90:  lane_hi = 34'sd5898240;
                    MOTOR_150: lane_hi = 34'sd9830400;
                    MOTOR_320: lane_hi = 34'sd20971520;
                endcase
            end
            default:  lane_hi = '0;
        endcase
    endfunction

    // Lower clamp limit of a lane, Q16.16.
    function automatic val_t lane_lo(input logic [2:0] lane, input motor_class_t cls);
        unique case (lane)
            LANE_KP:  lane_lo = '0;
            LANE_KD:  lane_lo = '0;
            LANE_POS: lane_lo = -34'sd819200;
            LANE_SPD: lane_lo = -34'sd1179648;
            LANE_TOR: lane_lo = -lane_hi(LANE_TOR, cls);
            default:  lane_lo = '0;
        endcase
    endfunction

    // Largest code of a lane, 2^n - 1.
    function automatic logic [TOP_W-1:0] lane_top(input logic [2:0] lane);
        unique case (lane)
            LANE_KP:  lane_top = 16'd4095;
            LANE_KD:  lane_top = 16'd511;
            LANE_POS: lane_top = 16'd65535;
            LANE_SPD: lane_top = 16'd4095;
            LANE_TOR: lane_top = 16'd4095;
            default:  lane_top = '0;
        endcase
    endfunction

    // Span of a lane in whole units.
    function automatic logic [DIV_W-1:0] lane_div(input logic [2:0] lane,
                                                  input motor_class_t cls);
        unique case (lane)
            LANE_KP:  lane_div = 11'd1500;
            LANE_KD:  lane_div = 11'd50;
            LANE_POS: lane_div = 11'd25;
            LANE_SPD: lane_div = 11'd36;
            LANE_TOR:
            begin
                unique case (cls)
                    MOTOR_30:  lane_div = 11'd60;
                    MOTOR_90:  lane_div = 11'd180;
                    MOTOR_150: lane_div = 11'd300;
                    MOTOR_320: lane_div = 11'd640;
                endcase
            end
            default:  lane_div = 11'd1;
        endcase
    endfunction

    // floor(2^24 / span); the estimate lands at most one below the quotient.
    function automatic logic [RECIP_W-1:0] lane_recip(input logic [2:0] lane,
                                                      input motor_class_t cls);
        unique case (lane)
            LANE_KP:  lane_recip = 20'd11184;
            LANE_KD:  lane_recip = 20'd335544;
            LANE_POS: lane_recip = 20'd671088;
            LANE_SPD: lane_recip = 20'd466033;
            LANE_TOR:
            begin
                unique case (cls)
                    MOTOR_30:  lane_recip = 20'd279620;
                    MOTOR_90:  lane_recip = 20'd93206;
                    MOTOR_150: lane_recip = 20'd55924;
                    MOTOR_320: lane_recip = 20'd26214;
                endcase
            end
            default:  lane_recip = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: hdl/icfp_clamp.sv
// First stage: offset the position, clamp every lane and shift it to a floor of zero.
`default_nettype none

module icfp_clamp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        stiffness,
    input  logic signed [31:0]        damping,
    input  logic signed [31:0]        target_position,
    input  logic signed [31:0]        target_speed,
    input  logic signed [31:0]        feed_torque,
    input  logic signed [31:0]        zero_offset,
    input  icfp_pkg::motor_class_t    motor_class,
    output logic                      out_valid,
    input  logic                      out_ready,
    output icfp_pkg::dist_stage_t     out_data
);
    import icfp_pkg::*;

    val_t        x [NUM_LANES];
    dist_stage_t data_next;
    dist_stage_t data_reg;
    logic        valid_next;
    logic        valid_reg;

    always_comb
    begin
        x[LANE_KP]  = {{2{stiffness[31]}}, stiffness};
        x[LANE_KD]  = {{2{damping[31]}}, damping};
        x[LANE_POS] = {{2{target_position[31]}}, target_position}
                    + {{2{zero_offset[31]}}, zero_offset};
        x[LANE_SPD] = {{2{target_speed[31]}}, target_speed};
        x[LANE_TOR] = {{2{feed_torque[31]}}, feed_torque};
    end

    always_comb
    begin : clamp_lanes
        val_t hi;
        val_t lo;
        val_t xc;
        val_t diff;
        data_next.cls = motor_class;
        data_next.d   = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            hi = lane_hi(3'(i), motor_class);
            lo = lane_lo(3'(i), motor_class);
            if (x[3'(i)] > hi)
                xc = hi;
            else if (x[3'(i)] < lo)
                xc = lo;
            else
                xc = x[3'(i)];
            diff = xc - lo;
            data_next.d[3'(i)] = diff[DIST_W-1:0];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: hdl/icfp_scale.sv
// Second stage: scale each lane by its largest code and drop the fraction bits.
`default_nettype none

module icfp_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  icfp_pkg::dist_stage_t     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output icfp_pkg::quot_stage_t     out_data
);
    import icfp_pkg::*;

    quot_stage_t data_next;
    quot_stage_t data_reg;
    logic        valid_next;
    logic        valid_reg;

    always_comb
    begin : scale_lanes
        logic [DIST_W+TOP_W-1:0] prod;
        data_next.cls = in_data.cls;
        data_next.q   = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            prod = (DIST_W+TOP_W)'(in_data.d[3'(i)]) * (DIST_W+TOP_W)'(lane_top(3'(i)));
            data_next.q[3'(i)] = prod[QUOT_W+15:16];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: hdl/icfp_recip.sv
// Third stage: estimate each quotient by a reciprocal multiply.
`default_nettype none

module icfp_recip (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  icfp_pkg::quot_stage_t     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output icfp_pkg::est_stage_t      out_data
);
    import icfp_pkg::*;

    est_stage_t data_next;
    est_stage_t data_reg;
    logic       valid_next;
    logic       valid_reg;

    always_comb
    begin : recip_lanes
        logic [QUOT_W+RECIP_W-1:0] prod;
        data_next.cls = in_data.cls;
        data_next.q   = in_data.q;
        data_next.est = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            prod = (QUOT_W+RECIP_W)'(in_data.q[3'(i)])
                 * (QUOT_W+RECIP_W)'(lane_recip(3'(i), in_data.cls));
            data_next.est[3'(i)] = prod[RECIP_SHIFT+CODE_W-1:RECIP_SHIFT];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: hdl/icfp_pack.sv
// Fourth stage: correct each quotient by one step and pack the codes into the frame.
`default_nettype none

module icfp_pack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  icfp_pkg::est_stage_t      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output icfp_pkg::frame_t          out_frame
);
    import icfp_pkg::*;

    code_t  code [NUM_LANES];
    frame_t frame_next;
    frame_t frame_reg;
    logic   valid_next;
    logic   valid_reg;

    // Remainder below twice the span: one compare settles the quotient.
    always_comb
    begin : correct_lanes
        logic [CODE_W+DIV_W-1:0] ec;
        logic [CODE_W+DIV_W-1:0] rem;
        logic [DIV_W-1:0]        c;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            c   = lane_div(3'(i), in_data.cls);
            ec  = (CODE_W+DIV_W)'(in_data.est[3'(i)]) * (CODE_W+DIV_W)'(c);
            rem = (CODE_W+DIV_W)'(in_data.q[3'(i)]) - ec;
            code[3'(i)] = in_data.est[3'(i)] + CODE_W'(rem >= (CODE_W+DIV_W)'(c));
        end
    end

    always_comb
    begin
        frame_next[0] = {3'b000, code[LANE_KP][11:7]};
        frame_next[1] = {code[LANE_KP][6:0], code[LANE_KD][8]};
        frame_next[2] = code[LANE_KD][7:0];
        frame_next[3] = code[LANE_POS][15:8];
        frame_next[4] = code[LANE_POS][7:0];
        frame_next[5] = code[LANE_SPD][11:4];
        frame_next[6] = {code[LANE_SPD][3:0], code[LANE_TOR][11:8]};
        frame_next[7] = code[LANE_TOR][7:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            frame_reg <= frame_next;
    end

    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

endmodule

`default_nettype wire

// File: hdl/impedance_command_frame_packer_unit.sv
// Impedance command frame packer: one command beat in, one eight-byte frame beat out.
// Each command (kp, kd, position, speed, torque, all signed Q16.16) is clamped to its
// range and quantised to 12, 9, 16, 12 and 12 bit codes, which are packed into byte0
// to byte7; out_id carries the configured frame id. The unit accepts one beat every
// clock cycle while the output is not held; a command passes through four register
// stages in order: clamp, scale by the largest code, reciprocal multiply, and
// quotient correction with packing; the last holds the frame until the sink takes it.
// A held output back-pressures the stages in turn, so empty stages still absorb
// beats. Configuration (motor class, position zero offset, frame id) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the unit is
// idle, and the unit itself never checks this. Indexes beyond the list are ignored.
`default_nettype none

module impedance_command_frame_packer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] stiffness,
    input  logic signed [31:0] damping,
    input  logic signed [31:0] target_position,
    input  logic signed [31:0] target_speed,
    input  logic signed [31:0] feed_torque,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_id,
    output logic [7:0]         byte0,
    output logic [7:0]         byte1,
    output logic [7:0]         byte2,
    output logic [7:0]         byte3,
    output logic [7:0]         byte4,
    output logic [7:0]         byte5,
    output logic [7:0]         byte6,
    output logic [7:0]         byte7
);
    import icfp_pkg::*;

    motor_class_t       motor_class_reg;
    logic signed [31:0] zero_offset_reg;
    logic [15:0]        frame_id_reg;

    logic        clamp_valid;
    logic        clamp_ready;
    dist_stage_t clamp_data;
    logic        scale_valid;
    logic        scale_ready;
    quot_stage_t scale_data;
    logic        recip_valid;
    logic        recip_ready;
    est_stage_t  recip_data;
    frame_t      frame;

    // Configuration registers; the user must write them only while no beat is in flight (unchecked here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_class_reg <= MOTOR_30;
            zero_offset_reg <= '0;
            frame_id_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOTOR_CLASS: motor_class_reg <= motor_class_t'(cfg_data[1:0]);
                CFG_ZERO_OFFSET: zero_offset_reg <= cfg_data;
                CFG_FRAME_ID:    frame_id_reg    <= cfg_data[15:0];
                default:         ;  // drop writes beyond the register list
            endcase
        end
    end

    // Stage 1: offset, clamp, shift to a zero floor.
    icfp_clamp u_clamp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stiffness       (stiffness),
        .damping         (damping),
        .target_position (target_position),
        .target_speed    (target_speed),
        .feed_torque     (feed_torque),
        .zero_offset     (zero_offset_reg),
        .motor_class     (motor_class_reg),
        .out_valid       (clamp_valid),
        .out_ready       (clamp_ready),
        .out_data        (clamp_data)
    );

    // Stage 2: multiply by 2^n - 1 and drop the sixteen fraction bits.
    icfp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (clamp_valid),
        .in_ready  (clamp_ready),
        .in_data   (clamp_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    // Stage 3: quotient estimate by the span's reciprocal.
    icfp_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (recip_valid),
        .out_ready (recip_ready),
        .out_data  (recip_data)
    );

    // Stage 4: correct, pack and hold the frame until it is taken.
    icfp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (recip_valid),
        .in_ready  (recip_ready),
        .in_data   (recip_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_frame (frame)
    );

    // From the register; the user must keep the id static while beats are in flight (unchecked here).
    assign out_id = frame_id_reg;
    assign byte0  = frame[0];
    assign byte1  = frame[1];
    assign byte2  = frame[2];
    assign byte3  = frame[3];
    assign byte4  = frame[4];
    assign byte5  = frame[5];
    assign byte6  = frame[6];
    assign byte7  = frame[7];

endmodule

`default_nettype wire

// File: hdl/icfp_checker.sv
// Port-level checker for the frame packer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module icfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [31:0] stiffness,
    input logic signed [31:0] damping,
    input logic signed [31:0] target_position,
    input logic signed [31:0] target_speed,
    input logic signed [31:0] feed_torque,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        out_id,
    input logic [7:0]         byte0,
    input logic [7:0]         byte1,
    input logic [7:0]         byte2,
    input logic [7:0]         byte3,
    input logic [7:0]         byte4,
    input logic [7:0]         byte5,
    input logic [7:0]         byte6,
    input logic [7:0]         byte7
);

    logic         took_in;
    logic         drain_ok;
    logic [159:0] cmd_word;
    logic [79:0]  frame_word;

    assign took_in    = in_valid && in_ready;
    assign drain_ok   = rst_n && out_ready;
    assign cmd_word   = {stiffness, damping, target_position, target_speed, feed_torque};
    assign frame_word = {out_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7};

    // Reset flushes the output stage by the next edge.
    property p_reset_empty;
        !rst_n |=> !out_valid;
    endproperty

    // A free output stage lets every stage advance, so the input must be ready.
    property p_ready_when_free;
        (!out_valid || out_ready) |-> in_ready;
    endproperty

    // With the sink always ready, a command passes each stage into a frame.
    property p_latency;
        ($past(took_in && rst_n, 4) && $past(drain_ok, 3) && $past(drain_ok, 2)
            && $past(drain_ok, 1)) |-> out_valid;
    endproperty

    // A stalled command holds.
    property p_in_hold;
        (in_valid && !in_ready) |=> (in_valid && $stable(cmd_word));
    endproperty

    // A stalled frame holds.
    property p_out_hold;
        (out_valid && !out_ready) |=> (out_valid && $stable(frame_word));
    endproperty

    `ICFP_ASSERT_ALWAYS(a_reset_empty, clk, p_reset_empty, "output valid after reset")
    `ICFP_ASSERT(a_ready_when_free, clk, rst_n, p_ready_when_free, "input stalled, output free")
    `ICFP_ASSERT(a_latency, clk, rst_n, p_latency, "frame missing after four cycles")
    `ICFP_ASSERT(a_in_hold, clk, rst_n, p_in_hold, "stalled command changed")
    `ICFP_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "stalled frame changed")

endmodule

bind impedance_command_frame_packer_unit icfp_checker u_icfp_checker (.*);

`default_nettype wire
